@@ design/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ design/yuvpsnr_pkg.sv @@
// shared types and constants of the yuv420 plane psnr core
`default_nettype none
package yuvpsnr_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int SQ_W        = 16;
   localparam int SUM_W       = 40;
   localparam int PEAK_W      = 16;
   localparam int PSNR_W      = 15;
   localparam int LOG_FRAC    = 28;
   localparam int ITER_W      = 5;
   localparam int MANT_W      = 32;
   localparam int PROD_W      = 64;
   localparam int CAP_DB      = 100;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [PEAK_W-1:0] PEAK_SQ      = 16'd65025;
   localparam logic [29:0]       DB_PER_LOG2  = 30'd808071242;
   localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef enum logic [1:0] {
      MUL_PEAK   = 2'd0,
      MUL_SQUARE = 2'd1,
      MUL_K_LO   = 2'd2,
      MUL_K_HI   = 2'd3
   } mul_op_type;

   typedef struct packed {
      plane_type plane;
      logic      sse_zero;
   } plane_job_type;

   typedef struct packed {
      plane_type plane;
      logic      capped;
      logic      frame_done;
   } rsp_flags_type;

endpackage
`default_nettype wire

@@ design/yuvpsnr_accum.sv @@
// frame size registers, sample position and squared error accumulation
`default_nettype none
module yuvpsnr_accum #(
   parameter int MAX_SIDE = 4096,
   parameter int SIDE_W   = 13,
   parameter int LUMA_W   = 26
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [yuvpsnr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [yuvpsnr_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                   accept,
   input  wire logic [yuvpsnr_pkg::SAMPLE_W-1:0]       ref_sample,
   input  wire logic [yuvpsnr_pkg::SAMPLE_W-1:0]       test_sample,
   output logic                                        size_ok,
   output logic                                        job_start,
   output logic [LUMA_W-1:0]                           plane_size,
   output logic [yuvpsnr_pkg::SUM_W-1:0]               plane_sse,
   output yuvpsnr_pkg::plane_job_type                  job
);

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [yuvpsnr_pkg::CSR_DATA_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v < 2) begin
         r = SIDE_W'(2);
      end else if (v > MAX_SIDE) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   logic [SIDE_W-1:0]               width_ff, width_in;
   logic [SIDE_W-1:0]               height_ff, height_in;
   logic [LUMA_W-1:0]               luma_ff;
   logic                            size_ok_ff;
   logic [LUMA_W-1:0]               pos_ff, pos_in;
   logic [yuvpsnr_pkg::SUM_W-1:0]   sum_ff, sum_in;
   yuvpsnr_pkg::plane_type          plane_ff, plane_in;

   logic [yuvpsnr_pkg::SAMPLE_W:0]   diff;
   logic [yuvpsnr_pkg::SAMPLE_W-1:0] abs_diff;
   logic [yuvpsnr_pkg::SQ_W-1:0]     sq;
   logic [yuvpsnr_pkg::SUM_W:0]      sum_wide;
   logic [yuvpsnr_pkg::SUM_W-1:0]    sum_next;
   logic [LUMA_W:0]                  pos_next;
   logic                             last;

   // registers are kept already clamped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            yuvpsnr_pkg::CSR_FRAME_WIDTH:  width_in  = clamp_side(csr_data);
            yuvpsnr_pkg::CSR_FRAME_HEIGHT: height_in = clamp_side(csr_data);
            default: ;
         endcase
      end
   end

   assign plane_size = (plane_ff == yuvpsnr_pkg::PLANE_Y) ? luma_ff : (luma_ff >> 2);

   always_comb begin
      diff     = {1'b0, test_sample} - {1'b0, ref_sample};
      abs_diff = diff[yuvpsnr_pkg::SAMPLE_W] ? yuvpsnr_pkg::SAMPLE_W'(-diff)
                                             : diff[yuvpsnr_pkg::SAMPLE_W-1:0];
      sq       = yuvpsnr_pkg::SQ_W'(abs_diff) * yuvpsnr_pkg::SQ_W'(abs_diff);
      sum_wide = {1'b0, sum_ff} + (yuvpsnr_pkg::SUM_W + 1)'(sq);
      sum_next = sum_wide[yuvpsnr_pkg::SUM_W] ? yuvpsnr_pkg::SUM_MAX
                                              : sum_wide[yuvpsnr_pkg::SUM_W-1:0];
      pos_next = {1'b0, pos_ff} + (LUMA_W + 1)'(1);
      last     = pos_next >= {1'b0, plane_size};
   end

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      plane_in = plane_ff;
      if (accept) begin
         if (last) begin
            pos_in = '0;
            sum_in = '0;
            case (plane_ff)
               yuvpsnr_pkg::PLANE_Y: plane_in = yuvpsnr_pkg::PLANE_U;
               yuvpsnr_pkg::PLANE_U: plane_in = yuvpsnr_pkg::PLANE_V;
               default:              plane_in = yuvpsnr_pkg::PLANE_Y;
            endcase
         end else begin
            pos_in = pos_next[LUMA_W-1:0];
            sum_in = sum_next;
         end
      end
   end

   assign job_start    = accept & last;
   assign plane_sse    = sum_next;
   assign job.plane    = (plane_ff == yuvpsnr_pkg::PLANE_Y) ? yuvpsnr_pkg::PLANE_Y :
                         (plane_ff == yuvpsnr_pkg::PLANE_U) ? yuvpsnr_pkg::PLANE_U :
                                                              yuvpsnr_pkg::PLANE_V;
   assign job.sse_zero = (sum_next == '0);
   assign size_ok      = size_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= clamp_side(yuvpsnr_pkg::CSR_DATA_W'(352));
         height_ff  <= clamp_side(yuvpsnr_pkg::CSR_DATA_W'(288));
         size_ok_ff <= 1'b0;
         pos_ff     <= '0;
         sum_ff     <= '0;
         plane_ff   <= yuvpsnr_pkg::PLANE_Y;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         size_ok_ff <= ~csr_write_enable;
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         plane_ff   <= plane_in;
      end
   end

   // luma size is registered from the side registers and follows them in the next cycle
   always_ff @(posedge clock) begin
      luma_ff <= LUMA_W'(width_ff) * LUMA_W'(height_ff);
   end

endmodule
`default_nettype wire

@@ design/yuvpsnr_mul.sv @@
// shared 32x32 multiplier with operand selection
`default_nettype none
module yuvpsnr_mul #(
   parameter int LUMA_W = 26,
   parameter int L_W    = 34
) (
   input  wire yuvpsnr_pkg::mul_op_type             op,
   input  wire logic [LUMA_W-1:0]                   n,
   input  wire logic [yuvpsnr_pkg::MANT_W-1:0]      mant,
   input  wire logic [L_W-1:0]                      log_ratio,
   output logic [yuvpsnr_pkg::PROD_W-1:0]           product
);

   logic [yuvpsnr_pkg::MANT_W-1:0] a;
   logic [yuvpsnr_pkg::MANT_W-1:0] b;

   always_comb begin
      case (op)
         yuvpsnr_pkg::MUL_PEAK: begin
            a = yuvpsnr_pkg::MANT_W'(n);
            b = yuvpsnr_pkg::MANT_W'(yuvpsnr_pkg::PEAK_SQ);
         end
         yuvpsnr_pkg::MUL_SQUARE: begin
            a = mant;
            b = mant;
         end
         yuvpsnr_pkg::MUL_K_LO: begin
            a = log_ratio[yuvpsnr_pkg::MANT_W-1:0];
            b = yuvpsnr_pkg::MANT_W'(yuvpsnr_pkg::DB_PER_LOG2);
         end
         yuvpsnr_pkg::MUL_K_HI: begin
            a = yuvpsnr_pkg::MANT_W'(log_ratio[L_W-1:yuvpsnr_pkg::MANT_W]);
            b = yuvpsnr_pkg::MANT_W'(yuvpsnr_pkg::DB_PER_LOG2);
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
   end

   assign product = yuvpsnr_pkg::PROD_W'(a) * yuvpsnr_pkg::PROD_W'(b);

endmodule
`default_nettype wire

@@ design/yuvpsnr_logseq.sv @@
// log-ratio sequencer: normalize, repeated squaring, scale to decibels
`default_nettype none
module yuvpsnr_logseq #(
   parameter int LUMA_W         = 26,
   parameter int PSNR_FRAC_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [LUMA_W-1:0]                  plane_size,
   input  wire logic [yuvpsnr_pkg::SUM_W-1:0]      plane_sse,
   input  wire yuvpsnr_pkg::plane_job_type         job,
   input  wire logic                               out_free,
   output logic                                    busy,
   output logic                                    done,
   output logic [yuvpsnr_pkg::PSNR_W-1:0]          psnr_value,
   output yuvpsnr_pkg::rsp_flags_type              flags
);

   localparam int WORD_W = (LUMA_W + yuvpsnr_pkg::PEAK_W > yuvpsnr_pkg::SUM_W) ?
                           LUMA_W + yuvpsnr_pkg::PEAK_W : yuvpsnr_pkg::SUM_W;
   localparam int E_W    = $clog2(WORD_W);
   localparam int L_W    = E_W + yuvpsnr_pkg::LOG_FRAC;
   localparam int VAL_W  = PSNR_FRAC_BITS + 8;
   localparam logic [E_W-1:0]   E_TOP     = E_W'(WORD_W - 1);
   localparam logic [yuvpsnr_pkg::ITER_W-1:0] ITER_LAST =
      yuvpsnr_pkg::ITER_W'(yuvpsnr_pkg::LOG_FRAC - 1);
   localparam logic [VAL_W-1:0] CAP_Q     = VAL_W'(yuvpsnr_pkg::CAP_DB) << PSNR_FRAC_BITS;
   localparam logic [yuvpsnr_pkg::PROD_W-1:0] PROD_CAP =
      yuvpsnr_pkg::PROD_W'(yuvpsnr_pkg::CAP_DB) << 56;
   localparam logic [yuvpsnr_pkg::PROD_W-1:0] ROUND_HALF =
      yuvpsnr_pkg::PROD_W'(1) << (55 - PSNR_FRAC_BITS);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PEAK  = 8'b0000_0010,
      S_NORM  = 8'b0000_0100,
      S_SQR   = 8'b0000_1000,
      S_LOG   = 8'b0001_0000,
      S_MULLO = 8'b0010_0000,
      S_MULHI = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } seq_state_type;

   seq_state_type                          state_ff, state_in;
   logic [LUMA_W-1:0]                      n_ff, n_in;
   logic [yuvpsnr_pkg::SUM_W-1:0]          sse_ff, sse_in;
   yuvpsnr_pkg::plane_job_type             job_ff, job_in;
   logic [WORD_W-1:0]                      work_ff, work_in;
   logic [E_W-1:0]                         e_ff, e_in;
   logic [yuvpsnr_pkg::MANT_W-1:0]         mant_ff, mant_in;
   logic [yuvpsnr_pkg::LOG_FRAC-1:0]       frac_ff, frac_in;
   logic [yuvpsnr_pkg::ITER_W-1:0]         iter_ff, iter_in;
   logic                                   pass_ff, pass_in;
   logic [L_W-1:0]                         ln_ff, ln_in;
   logic [L_W-1:0]                         l_ff, l_in;
   logic [yuvpsnr_pkg::PROD_W-1:0]         prod_ff, prod_in;

   yuvpsnr_pkg::mul_op_type                op;
   logic [yuvpsnr_pkg::PROD_W-1:0]         product;
   logic [yuvpsnr_pkg::MANT_W:0]           sq_top;
   logic [L_W-1:0]                         log_val;
   logic [yuvpsnr_pkg::PROD_W-1:0]         rounded;
   logic [yuvpsnr_pkg::PROD_W-1:0]         val_wide;
   logic [VAL_W-1:0]                       val;
   logic                                   capped;
   logic [VAL_W-1:0]                       val_final;

   always_comb begin
      case (state_ff)
         S_PEAK:  op = yuvpsnr_pkg::MUL_PEAK;
         S_MULLO: op = yuvpsnr_pkg::MUL_K_LO;
         S_MULHI: op = yuvpsnr_pkg::MUL_K_HI;
         default: op = yuvpsnr_pkg::MUL_SQUARE;
      endcase
   end

   yuvpsnr_mul #(
      .LUMA_W (LUMA_W),
      .L_W    (L_W)
   ) u_mul (
      .op        (op),
      .n         (n_ff),
      .mant      (mant_ff),
      .log_ratio (l_ff),
      .product   (product)
   );

   assign sq_top  = product[yuvpsnr_pkg::PROD_W-1:31];
   assign log_val = {e_ff, frac_ff};

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      sse_in   = sse_ff;
      job_in   = job_ff;
      work_in  = work_ff;
      e_in     = e_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      iter_in  = iter_ff;
      pass_in  = pass_ff;
      ln_in    = ln_ff;
      l_in     = l_ff;
      prod_in  = prod_ff;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = plane_size;
               sse_in   = plane_sse;
               job_in   = job;
               state_in = S_PEAK;
            end
         end
         S_PEAK: begin
            work_in  = WORD_W'(product);
            e_in     = E_TOP;
            pass_in  = 1'b0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (work_ff[WORD_W-1]) begin
               mant_in  = work_ff[WORD_W-1 -: yuvpsnr_pkg::MANT_W];
               frac_in  = '0;
               iter_in  = '0;
               state_in = S_SQR;
            end else begin
               work_in = work_ff << 1;
               e_in    = e_ff - E_W'(1);
            end
         end
         S_SQR: begin
            if (sq_top[yuvpsnr_pkg::MANT_W]) begin
               mant_in = sq_top[yuvpsnr_pkg::MANT_W:1];
               frac_in = {frac_ff[yuvpsnr_pkg::LOG_FRAC-2:0], 1'b1};
            end else begin
               mant_in = sq_top[yuvpsnr_pkg::MANT_W-1:0];
               frac_in = {frac_ff[yuvpsnr_pkg::LOG_FRAC-2:0], 1'b0};
            end
            iter_in = iter_ff + yuvpsnr_pkg::ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            if (!pass_ff) begin
               ln_in    = log_val;
               work_in  = (sse_ff == '0) ? WORD_W'(1) : WORD_W'(sse_ff);
               e_in     = E_TOP;
               pass_in  = 1'b1;
               state_in = S_NORM;
            end else begin
               l_in     = (ln_ff > log_val) ? (ln_ff - log_val) : '0;
               state_in = S_MULLO;
            end
         end
         S_MULLO: begin
            prod_in  = product;
            state_in = S_MULHI;
         end
         S_MULHI: begin
            prod_in  = prod_ff + {product[yuvpsnr_pkg::MANT_W-1:0],
                                  {yuvpsnr_pkg::MANT_W{1'b0}}};
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // round to nearest at the output fraction, cap at 100 dB
   always_comb begin
      rounded   = prod_ff + ROUND_HALF;
      val_wide  = rounded >> (56 - PSNR_FRAC_BITS);
      val       = val_wide[VAL_W-1:0];
      capped    = job_ff.sse_zero | (prod_ff > PROD_CAP);
      val_final = (capped || (val > CAP_Q)) ? CAP_Q : val;
   end

   assign psnr_value       = yuvpsnr_pkg::PSNR_W'(val_final);
   assign flags.plane      = job_ff.plane;
   assign flags.capped     = capped;
   assign flags.frame_done = (job_ff.plane == yuvpsnr_pkg::PLANE_V);
   assign busy             = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      sse_ff  <= sse_in;
      job_ff  <= job_in;
      work_ff <= work_in;
      e_ff    <= e_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      iter_ff <= iter_in;
      pass_ff <= pass_in;
      ln_ff   <= ln_in;
      l_ff    <= l_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

@@ design/yuv420_plane_psnr_core.sv @@
// psnr core: one sample pair a cycle when not stalled, log sequence at each plane end
// result path after the plane's last pair: peak multiply, then per operand normalize over
//   WORD_W bits (42 by default) and squarings, log difference, scale multiplies, output register
// throughput: one pair per cycle inside a plane; the shared 32x32 multiplier runs 56 squarings
//   at each plane end; input stalls while the sequence runs, while a finished word waits, and
//   in the cycle after each csr write; reset: synchronous, clears position, sum, plane, sequencer
`default_nettype none
`include "assert_macros.svh"
module yuv420_plane_psnr_core #(
   parameter int MAX_SIDE       = 4096,
   parameter int PSNR_FRAC_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample pair input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [yuvpsnr_pkg::SAMPLE_W-1:0]    req_ref_sample,
   input  wire logic [yuvpsnr_pkg::SAMPLE_W-1:0]    req_test_sample,
   // plane result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_plane_id,
   output logic [yuvpsnr_pkg::PSNR_W-1:0]           rsp_psnr_value,
   output logic                                     rsp_capped,
   output logic                                     rsp_frame_done,
   // register writes
   input  wire logic                                csr_write_enable,
   input  wire logic [yuvpsnr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [yuvpsnr_pkg::CSR_DATA_W-1:0]  csr_data
);

   // side width holds MAX_SIDE itself, luma size is the product of two sides
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int LUMA_W = 2 * SIDE_W;

   logic                               accept;
   logic                               size_ok;
   logic                               job_start;
   logic [LUMA_W-1:0]                  plane_size;
   logic [yuvpsnr_pkg::SUM_W-1:0]      plane_sse;
   yuvpsnr_pkg::plane_job_type         job;
   logic                               seq_busy;
   logic                               seq_done;
   logic [yuvpsnr_pkg::PSNR_W-1:0]     seq_value;
   yuvpsnr_pkg::rsp_flags_type         seq_flags;
   logic                               out_free;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [yuvpsnr_pkg::PSNR_W-1:0]     rsp_value_ff;
   yuvpsnr_pkg::rsp_flags_type         rsp_flags_ff;

   // pairs are refused while the log sequence runs and while the luma size
   // register catches up with a fresh side write
   assign req_stall = seq_busy | ~size_ok;
   assign accept    = req_valid & ~req_stall;

   yuvpsnr_accum #(
      .MAX_SIDE (MAX_SIDE),
      .SIDE_W   (SIDE_W),
      .LUMA_W   (LUMA_W)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .accept           (accept),
      .ref_sample       (req_ref_sample),
      .test_sample      (req_test_sample),
      .size_ok          (size_ok),
      .job_start        (job_start),
      .plane_size       (plane_size),
      .plane_sse        (plane_sse),
      .job              (job)
   );

   // the sequencer holds its finished result until the output word is free
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   yuvpsnr_logseq #(
      .LUMA_W         (LUMA_W),
      .PSNR_FRAC_BITS (PSNR_FRAC_BITS)
   ) u_logseq (
      .clock      (clock),
      .reset      (reset),
      .start      (job_start),
      .plane_size (plane_size),
      .plane_sse  (plane_sse),
      .job        (job),
      .out_free   (out_free),
      .busy       (seq_busy),
      .done       (seq_done),
      .psnr_value (seq_value),
      .flags      (seq_flags)
   );

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_value_ff <= seq_value;
         rsp_flags_ff <= seq_flags;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plane_id   = rsp_flags_ff.plane;
   assign rsp_psnr_value = rsp_value_ff;
   assign rsp_capped     = rsp_flags_ff.capped;
   assign rsp_frame_done = rsp_flags_ff.frame_done;

   // a plane end must launch the sequencer
   `ASSERT_NEXT(a_start_busy, clock, reset, job_start, seq_busy)
   // the sequencer never overwrites a word still waiting at the output
   `ASSERT_IMPLY(a_done_slot_free, clock, reset, seq_done, !rsp_valid_ff || !rsp_stall)
   // frame close is only flagged on the v plane
   `ASSERT_IMPLY(a_frame_done_v, clock, reset, rsp_valid_ff && rsp_flags_ff.frame_done, rsp_flags_ff.plane == yuvpsnr_pkg::PLANE_V)

endmodule
`default_nettype wire
